/* design/ascii_vertex_decimal_parser_top_defines.svh */
// assertion macros shared by the parser modules
`ifndef ASCII_VERTEX_DECIMAL_PARSER_TOP_DEFINES_SVH
`define ASCII_VERTEX_DECIMAL_PARSER_TOP_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define AVDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("avdp same-cycle check failed");

// next-cycle implication, sampled on aclk, off while in reset
`define AVDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("avdp next-cycle check failed");

`endif

/* design/avdp_pkg.sv */
package avdp_pkg;

    // field widths
    localparam int unsigned CHAR_W       = 8;
    localparam int unsigned COORD_W      = 32;
    localparam int unsigned TDATA_W      = 3 * COORD_W;
    localparam int unsigned INT_ACC_W    = 15;
    localparam int unsigned INT_MUL_W    = INT_ACC_W + 4;
    localparam int unsigned FRAC_ACC_W   = 30;
    localparam int unsigned FRAC_MUL_W   = FRAC_ACC_W + 4;
    localparam int unsigned CNT_W        = 4;
    localparam int unsigned LOG_W        = 5;
    localparam int unsigned HELD_N       = 2;
    localparam int unsigned FRAC_TABLE_N = 10;

    // default number of fraction bits of the output coordinates
    localparam int unsigned FRACTION_BITS_DEF = 16;

    // parse limits
    localparam logic [CNT_W-1:0]     MAX_FRACTION_DIGITS = 4'd9;
    localparam logic [INT_ACC_W-1:0] INT_LIMIT           = 15'd32767;
    localparam logic [3:0]           DECIMAL_BASE        = 4'd10;

    // characters of interest
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

    // powers of ten by fraction digit count
    localparam logic [FRAC_ACC_W-1:0] POW10 [FRAC_TABLE_N] = '{
        30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
        30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
    };

    // ceil(log2(10^k)), so that 2^L >= 10^k > 2^(L-1)
    localparam logic [LOG_W-1:0] LOG2_POW10 [FRAC_TABLE_N] = '{
        5'd0, 5'd4, 5'd7, 5'd10, 5'd14, 5'd17, 5'd20, 5'd24, 5'd27, 5'd30
    };

    // one number as the text gave it
    typedef struct packed {
        logic                  neg;
        logic [INT_ACC_W-1:0]  int_acc;
        logic [FRAC_ACC_W-1:0] frac_acc;
        logic [CNT_W-1:0]      frac_cnt;
    } num_raw_t;

    // one complete vertex waiting for conversion
    typedef struct packed {
        num_raw_t x;
        num_raw_t y;
        num_raw_t z;
        logic     sat;
    } vertex_raw_t;

endpackage

/* design/ascii_vertex_decimal_parser_top.sv */
// A result leaves once the '\n' or NUL item that ends its line has passed through the
// input register, parse step, vertex register, then three conversion stages.
// Throughput: one character item per cycle, but a line end waits for a free vertex register.
// The fraction scaling runs as a reciprocal multiply and a check multiply per lane.
// Reset: aresetn low at a clock edge empties every stage and sets the parser idle.
module ascii_vertex_decimal_parser_top
    import avdp_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] character
    input  logic               s_tuser,   // [0] start_vertex
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [31:0] x_coord, [63:32] y_coord, [95:64] z_coord
    output logic               m_tuser    // [0] integer_saturated
);

    logic        vtx_valid;
    logic        vtx_ready;
    vertex_raw_t vtx;

    // text parsing
    avdp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx)
    );

    // fixed-point conversion
    avdp_convert #(.FRACTION_BITS(FRACTION_BITS)) u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* design/avdp_parser.sv */
`include "ascii_vertex_decimal_parser_top_defines.svh"

module avdp_parser
    import avdp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] character
    input  logic              s_tuser,   // [0] start_vertex
    output logic              vtx_valid,
    input  logic              vtx_ready,
    output vertex_raw_t       vtx
);

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_SEARCH   = 5'b00010,
        PH_INTEGER  = 5'b00100,
        PH_FRACTION = 5'b01000,
        PH_SKIP     = 5'b10000
    } phase_t;

    logic              in_v_reg, in_v_next;
    logic [CHAR_W-1:0] in_char_reg, in_char_next;
    logic              in_start_reg, in_start_next;
    phase_t            phase_reg, phase_next;
    logic [1:0]        idx_reg, idx_next;
    num_raw_t          cur_reg, cur_next;
    num_raw_t          held_reg [HELD_N];
    num_raw_t          held_next [HELD_N];
    logic              sat_reg, sat_next;
    logic              ev_reg, ev_next;
    vertex_raw_t       vtx_reg, vtx_next;

    logic              step;
    logic              emit;
    logic              out_free;
    logic              is_digit;
    logic              is_minus;
    logic              is_nul;
    logic              is_end_line;
    logic [3:0]        dval;
    logic [INT_MUL_W-1:0]  int_mul;
    logic [FRAC_MUL_W-1:0] frac_mul;
    num_raw_t          start_num;

    // character classes
    assign is_digit    = (in_char_reg >= CH_ZERO) && (in_char_reg <= CH_NINE);
    assign is_minus    = (in_char_reg == CH_MINUS);
    assign is_nul      = (in_char_reg == CH_NUL);
    assign is_end_line = (in_char_reg == CH_NEWLINE) || is_nul;
    assign dval        = 4'(in_char_reg - CH_ZERO);

    // digit accumulation
    assign int_mul  = INT_MUL_W'(cur_reg.int_acc) * INT_MUL_W'(DECIMAL_BASE)
                    + INT_MUL_W'(dval);
    assign frac_mul = FRAC_MUL_W'(cur_reg.frac_acc) * FRAC_MUL_W'(DECIMAL_BASE)
                    + FRAC_MUL_W'(dval);

    // a number opened by this character
    always_comb begin
        start_num          = '0;
        start_num.neg      = is_minus;
        start_num.int_acc  = is_digit ? INT_ACC_W'(dval) : '0;
    end

    // one parse step per item
    always_comb begin
        phase_t   ph;
        logic     end_num;
        ph           = phase_reg;
        end_num      = 1'b0;
        emit         = 1'b0;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        sat_next     = sat_reg;
        held_next[0] = held_reg[0];
        held_next[1] = held_reg[1];

        if (in_start_reg) begin
            idx_next = '0;
            sat_next = 1'b0;
            cur_next = '0;
            ph       = PH_SEARCH;
        end

        unique case (ph)
            PH_IDLE: begin
            end
            PH_SEARCH: begin
                if (is_digit || is_minus) begin
                    cur_next = start_num;
                    ph       = PH_INTEGER;
                end else if (is_nul) begin
                    ph = PH_IDLE;
                end
            end
            PH_INTEGER: begin
                if (is_digit) begin
                    if (int_mul > INT_MUL_W'(INT_LIMIT)) begin
                        cur_next.int_acc = INT_LIMIT;
                        sat_next         = 1'b1;
                    end else begin
                        cur_next.int_acc = int_mul[INT_ACC_W-1:0];
                    end
                end else if (in_char_reg == CH_POINT) begin
                    ph = PH_FRACTION;
                end else begin
                    end_num = 1'b1;
                end
            end
            PH_FRACTION: begin
                if (is_digit) begin
                    if (cur_reg.frac_cnt < MAX_FRACTION_DIGITS) begin
                        cur_next.frac_acc = frac_mul[FRAC_ACC_W-1:0];
                        cur_next.frac_cnt = cur_reg.frac_cnt + 4'd1;
                    end
                end else begin
                    end_num = 1'b1;
                end
            end
            PH_SKIP: begin
                if (is_end_line) begin
                    emit = 1'b1;
                    ph   = PH_IDLE;
                end
            end
            default: begin
                ph = PH_IDLE;
            end
        endcase

        // the ending character is looked at again
        if (end_num) begin
            if (idx_reg < 2'd2) begin
                held_next[idx_reg[0]] = cur_reg;
                idx_next              = idx_reg + 2'd1;
                ph                    = PH_SEARCH;
                if (is_digit || is_minus) begin
                    cur_next = start_num;
                    ph       = PH_INTEGER;
                end else if (is_nul) begin
                    ph = PH_IDLE;
                end
            end else begin
                ph = PH_SKIP;
                if (is_end_line) begin
                    emit = 1'b1;
                    ph   = PH_IDLE;
                end
            end
        end

        phase_next = ph;
    end

    // handshake toward the conversion pipeline
    assign out_free  = !ev_reg || vtx_ready;
    assign step      = in_v_reg && (!emit || out_free);
    assign s_tready  = !in_v_reg || step;
    assign vtx_valid = ev_reg;
    assign vtx       = vtx_reg;

    // input register
    always_comb begin
        in_v_next     = in_v_reg;
        in_char_next  = in_char_reg;
        in_start_next = in_start_reg;
        if (s_tvalid && s_tready) begin
            in_v_next     = 1'b1;
            in_char_next  = s_tdata;
            in_start_next = s_tuser;
        end else if (step) begin
            in_v_next = 1'b0;
        end
    end

    // vertex register
    always_comb begin
        ev_next  = ev_reg;
        vtx_next = vtx_reg;
        if (ev_reg && vtx_ready) begin
            ev_next = 1'b0;
        end
        if (step && emit) begin
            ev_next      = 1'b1;
            vtx_next.x   = held_reg[0];
            vtx_next.y   = held_reg[1];
            vtx_next.z   = cur_reg;
            vtx_next.sat = sat_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            cur_reg   <= '0;
            sat_reg   <= 1'b0;
            ev_reg    <= 1'b0;
        end else begin
            in_v_reg <= in_v_next;
            ev_reg   <= ev_next;
            if (step) begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                cur_reg   <= cur_next;
                sat_reg   <= sat_next;
            end
        end
    end

    // payload state
    always_ff @(posedge aclk) begin
        in_char_reg  <= in_char_next;
        in_start_reg <= in_start_next;
        vtx_reg      <= vtx_next;
        if (step) begin
            held_reg[0] <= held_next[0];
            held_reg[1] <= held_next[1];
        end
    end

    // a vertex leaves only once two numbers are held
    `AVDP_ASSERT_NOW(a_emit_after_two, step && emit, (idx_reg == 2'd2) && !in_start_reg)
    // skipping to end of line means all three numbers were found
    `AVDP_ASSERT_NOW(a_skip_index, phase_reg == PH_SKIP, idx_reg == 2'd2)
    // fraction digit count stays within the kept digits
    `AVDP_ASSERT_NOW(a_frac_cnt, 1'b1, cur_reg.frac_cnt <= MAX_FRACTION_DIGITS)

endmodule

/* design/avdp_lane.sv */
module avdp_lane
    import avdp_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               aclk,
    input  logic               en1,
    input  logic               en2,
    input  logic               en3,
    input  num_raw_t           num_in,
    output logic [COORD_W-1:0] coord,
    output logic               sat
);

    localparam int unsigned RECIP_W  = FRACTION_BITS + 1;
    localparam int unsigned PROD_W   = FRAC_ACC_W + RECIP_W;
    localparam int unsigned SCALED_W = FRAC_ACC_W + FRACTION_BITS;
    localparam int unsigned CHECK_W  = FRAC_ACC_W + RECIP_W;
    localparam int unsigned MAG_W    = INT_ACC_W + FRACTION_BITS;
    localparam int unsigned CMP_W    = (MAG_W > COORD_W) ? MAG_W : COORD_W + 1;

    localparam logic [CMP_W-1:0] POS_LIMIT = CMP_W'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam logic [CMP_W-1:0] NEG_LIMIT = CMP_W'(64'd1 << (COORD_W - 1));

    // floor(2^(FRACTION_BITS+L_k) / 10^k): the quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP [FRAC_TABLE_N] = '{
        RECIP_W'((64'd1 << (FRACTION_BITS + LOG2_POW10[0])) / 64'(POW10[0])),
        RECIP_W'((64'd1 << (FRACTION_BITS + LOG2_POW10[1])) / 64'(POW10[1])),
        RECIP_W'((64'd1 << (FRACTION_BITS + LOG2_POW10[2])) / 64'(POW10[2])),
        RECIP_W'((64'd1 << (FRACTION_BITS + LOG2_POW10[3])) / 64'(POW10[3])),
        RECIP_W'((64'd1 << (FRACTION_BITS + LOG2_POW10[4])) / 64'(POW10[4])),
        RECIP_W'((64'd1 << (FRACTION_BITS + LOG2_POW10[5])) / 64'(POW10[5])),
        RECIP_W'((64'd1 << (FRACTION_BITS + LOG2_POW10[6])) / 64'(POW10[6])),
        RECIP_W'((64'd1 << (FRACTION_BITS + LOG2_POW10[7])) / 64'(POW10[7])),
        RECIP_W'((64'd1 << (FRACTION_BITS + LOG2_POW10[8])) / 64'(POW10[8])),
        RECIP_W'((64'd1 << (FRACTION_BITS + LOG2_POW10[9])) / 64'(POW10[9]))
    };

    logic                     neg1_reg, neg2_reg;
    logic [INT_ACC_W-1:0]     int1_reg, int2_reg;
    logic [CNT_W-1:0]         k1_reg;
    logic [SCALED_W-1:0]      scaled1_reg, scaled2_reg;
    logic [PROD_W-1:0]        prod1_reg;
    logic [FRACTION_BITS-1:0] q2_reg;
    logic [CHECK_W-1:0]       chk2_reg;
    logic [COORD_W-1:0]       coord3_reg;
    logic                     sat3_reg;

    logic [PROD_W-1:0]        prod_shift;
    logic [FRACTION_BITS-1:0] q_est;
    logic [RECIP_W-1:0]       q_inc;
    logic                     bump;
    logic [FRACTION_BITS-1:0] q_fix;
    logic [CMP_W-1:0]         mag;
    logic [CMP_W-1:0]         limit;
    logic [CMP_W-1:0]         mag_clip;
    logic                     over;

    // stage 1: fraction times reciprocal
    always_ff @(posedge aclk) begin
        if (en1) begin
            neg1_reg    <= num_in.neg;
            int1_reg    <= num_in.int_acc;
            k1_reg      <= num_in.frac_cnt;
            scaled1_reg <= SCALED_W'(num_in.frac_acc) << FRACTION_BITS;
            prod1_reg   <= PROD_W'(num_in.frac_acc) * PROD_W'(RECIP[num_in.frac_cnt]);
        end
    end

    // stage 2: quotient estimate and the check product for estimate plus one
    assign prod_shift = prod1_reg >> LOG2_POW10[k1_reg];
    assign q_est      = prod_shift[FRACTION_BITS-1:0];
    assign q_inc      = RECIP_W'(q_est) + RECIP_W'(1);

    always_ff @(posedge aclk) begin
        if (en2) begin
            neg2_reg    <= neg1_reg;
            int2_reg    <= int1_reg;
            scaled2_reg <= scaled1_reg;
            q2_reg      <= q_est;
            chk2_reg    <= CHECK_W'(q_inc) * CHECK_W'(POW10[k1_reg]);
        end
    end

    // stage 3: correct the quotient, clamp and apply the sign
    assign bump     = (chk2_reg <= CHECK_W'(scaled2_reg));
    assign q_fix    = q2_reg + FRACTION_BITS'(bump);
    assign mag      = CMP_W'({int2_reg, q_fix});
    assign limit    = neg2_reg ? NEG_LIMIT : POS_LIMIT;
    assign over     = (mag > limit);
    assign mag_clip = over ? limit : mag;

    always_ff @(posedge aclk) begin
        if (en3) begin
            sat3_reg   <= over;
            coord3_reg <= neg2_reg ? (COORD_W'(0) - mag_clip[COORD_W-1:0])
                                   : mag_clip[COORD_W-1:0];
        end
    end

    assign coord = coord3_reg;
    assign sat   = sat3_reg;

endmodule

/* design/avdp_convert.sv */
`include "ascii_vertex_decimal_parser_top_defines.svh"

module avdp_convert
    import avdp_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               vtx_valid,
    output logic               vtx_ready,
    input  vertex_raw_t        vtx,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // [31:0] x_coord, [63:32] y_coord, [95:64] z_coord
    output logic               m_tuser   // [0] integer_saturated
);

    logic v1_reg, v2_reg, v3_reg;
    logic sat1_reg, sat2_reg, sat3_reg;
    logic ready1, ready2, ready3;

    logic [COORD_W-1:0] x_val, y_val, z_val;
    logic               x_sat, y_sat, z_sat;

    // a stage moves on when it is empty or the next one takes its item
    assign ready3    = !v3_reg || m_tready;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign vtx_ready = ready1;

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= vtx_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // parse-time saturation rides along
    always_ff @(posedge aclk) begin
        if (ready1) begin
            sat1_reg <= vtx.sat;
        end
        if (ready2) begin
            sat2_reg <= sat1_reg;
        end
        if (ready3) begin
            sat3_reg <= sat2_reg;
        end
    end

    // one conversion lane per coordinate
    avdp_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_x (
        .aclk   (aclk),
        .en1    (ready1),
        .en2    (ready2),
        .en3    (ready3),
        .num_in (vtx.x),
        .coord  (x_val),
        .sat    (x_sat)
    );

    avdp_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_y (
        .aclk   (aclk),
        .en1    (ready1),
        .en2    (ready2),
        .en3    (ready3),
        .num_in (vtx.y),
        .coord  (y_val),
        .sat    (y_sat)
    );

    avdp_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_z (
        .aclk   (aclk),
        .en1    (ready1),
        .en2    (ready2),
        .en3    (ready3),
        .num_in (vtx.z),
        .coord  (z_val),
        .sat    (z_sat)
    );

    // result item
    assign m_tvalid = v3_reg;
    assign m_tdata  = {z_val, y_val, x_val};
    assign m_tuser  = sat3_reg | x_sat | y_sat | z_sat;

    // a result only appears after a vertex sat in stage 2
    `AVDP_ASSERT_NOW(a_out_from_stage2, $rose(v3_reg), $past(v2_reg))
    // a blocked stage 2 keeps its vertex
    `AVDP_ASSERT_NEXT(a_stage2_hold, v2_reg && !ready3, v2_reg)
    // a blocked stage 1 keeps its vertex
    `AVDP_ASSERT_NEXT(a_stage1_hold, v1_reg && !ready2, v1_reg)

endmodule

/* tb/vertex_line_checker.sv */
module vertex_line_checker
    import avdp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] character
    input  logic               s_tuser,   // [0] start_vertex
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,   // [31:0] x, [63:32] y, [95:64] z
    input  logic               m_tuser,   // [0] integer_saturated
    output int                 vertices_owed,
    output int                 mismatches
);

    localparam int unsigned FRAC_BITS = FRACTION_BITS_DEF;

    typedef enum logic [2:0] {
        LINE_IDLE,
        SEEK_NUMBER,
        INT_DIGITS,
        FRAC_DIGITS,
        SKIP_TO_END
    } parse_phase_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               sat;
    } vertex_t;

    // shadow of the parser state
    parse_phase_t          phase;
    logic [1:0]            coord_idx;
    logic                  neg;
    logic [INT_ACC_W-1:0]  int_acc;
    logic [63:0]           frac_acc;
    logic [CNT_W-1:0]      frac_cnt;
    logic [COORD_W-1:0]    held [HELD_N];
    logic                  sat_seen;

    vertex_t expected_vertices [$];
    int      error_total = 0;

    function automatic logic [63:0] ten_to(input int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++) p = p * DECIMAL_BASE;
        return p;
    endfunction

    task automatic clear_number();
        neg      = 1'b0;
        int_acc  = '0;
        frac_acc = '0;
        frac_cnt = '0;
    endtask

    // fixed-point value of the number in the accumulators, clamped to the word
    task automatic number_to_fixed(output logic [COORD_W-1:0] val);
        logic [63:0] mag;
        logic [63:0] limit;
        mag   = 64'(int_acc) << FRAC_BITS;
        mag   = mag + (frac_acc << FRAC_BITS) / ten_to(int'(frac_cnt));
        limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (mag > limit) begin
            mag      = limit;
            sat_seen = 1'b1;
        end
        val = neg ? COORD_W'(64'd0 - mag) : mag[COORD_W-1:0];
    endtask

    // one character item through the parser; done marks a finished vertex
    task automatic parse_character(input logic [CHAR_W-1:0] ch, input logic first,
                                   output bit done, output vertex_t v);
        bit          is_digit;
        bit          number_ended;
        logic [7:0]  d;
        logic [31:0] t;
        done     = 1'b0;
        v        = '0;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        d        = ch - CH_ZERO;
        if (first) begin
            coord_idx = '0;
            sat_seen  = 1'b0;
            clear_number();
            phase     = SEEK_NUMBER;
        end
        number_ended = 1'b1;
        while (number_ended) begin
            number_ended = 1'b0;
            case (phase)
                SEEK_NUMBER: begin
                    if (is_digit || ch == CH_MINUS) begin
                        clear_number();
                        if (ch == CH_MINUS) neg = 1'b1;
                        else int_acc = INT_ACC_W'(d);
                        phase = INT_DIGITS;
                    end else if (ch == CH_NUL) begin
                        phase = LINE_IDLE;
                    end
                end
                INT_DIGITS: begin
                    if (is_digit) begin
                        t = 32'(int_acc) * DECIMAL_BASE + 32'(d);
                        if (t > 32'(INT_LIMIT)) begin
                            t        = 32'(INT_LIMIT);
                            sat_seen = 1'b1;
                        end
                        int_acc = INT_ACC_W'(t);
                    end else if (ch == CH_POINT) begin
                        phase = FRAC_DIGITS;
                    end else begin
                        number_ended = 1'b1;
                    end
                end
                FRAC_DIGITS: begin
                    if (is_digit) begin
                        // digits beyond the limit are dropped
                        if (frac_cnt < MAX_FRACTION_DIGITS) begin
                            frac_acc = frac_acc * DECIMAL_BASE + 64'(d);
                            frac_cnt = frac_cnt + 1'b1;
                        end
                    end else begin
                        number_ended = 1'b1;
                    end
                end
                SKIP_TO_END: begin
                    if (ch == CH_NEWLINE || ch == CH_NUL) begin
                        number_to_fixed(v.z);
                        v.x   = held[0];
                        v.y   = held[1];
                        v.sat = sat_seen;
                        done  = 1'b1;
                        phase = LINE_IDLE;
                    end
                end
                default: ;
            endcase
            // the ending character is looked at again
            if (number_ended) begin
                if (coord_idx < 2'd2) begin
                    number_to_fixed(held[coord_idx[0]]);
                    coord_idx = coord_idx + 1'b1;
                    phase     = SEEK_NUMBER;
                end else begin
                    phase = SKIP_TO_END;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_total++;
        end
    endtask

    // compare results, then predict from accepted items
    always @(posedge aclk) begin : watch
        vertex_t got;
        vertex_t want;
        vertex_t made;
        bit      done;
        if (!aresetn) begin
            phase     = LINE_IDLE;
            coord_idx = '0;
            clear_number();
            held[0]   = '0;
            held[1]   = '0;
            sat_seen  = 1'b0;
            expected_vertices.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.x   = m_tdata[COORD_W-1:0];
                got.y   = m_tdata[2*COORD_W-1:COORD_W];
                got.z   = m_tdata[3*COORD_W-1:2*COORD_W];
                got.sat = m_tuser;
                if (expected_vertices.size() == 0) begin
                    $display("%0t: unexpected vertex, expected none, actual %h %h %h %b",
                             $time, got.x, got.y, got.z, got.sat);
                    error_total++;
                end else begin
                    want = expected_vertices.pop_front();
                    check_field("x_coord", want.x, got.x);
                    check_field("y_coord", want.y, got.y);
                    check_field("z_coord", want.z, got.z);
                    check_field("integer_saturated", COORD_W'(want.sat), COORD_W'(got.sat));
                end
            end
            if (s_tvalid && s_tready) begin
                parse_character(s_tdata, s_tuser, done, made);
                if (done) expected_vertices.push_back(made);
            end
        end
        vertices_owed <= expected_vertices.size();
        mismatches    <= error_total;
    end

endmodule

/* tb/testbench.sv */
module testbench;
    import avdp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 330;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata  = '0;    // [7:0] character
    logic               s_tuser  = 1'b0;  // [0] start_vertex
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;          // [31:0] x, [63:32] y, [95:64] z
    logic               m_tuser;          // [0] integer_saturated

    int vertices_owed;
    int mismatches;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int cycle_count   = 0;

    logic [CHAR_W-1:0] line_text [$];

    always #5 aclk = ~aclk;

    ascii_vertex_decimal_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    vertex_line_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .vertices_owed (vertices_owed),
        .mismatches    (mismatches)
    );

    // receiver: long hold-off when asked, else random stalls
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // offer one character item, with random gaps before it
    task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic first);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_text(input string text, input bit begins_vertex);
        for (int i = 0; i < text.len(); i++) send_byte(text[i], begins_vertex && i == 0);
    endtask

    task automatic push_separator();
        case ($urandom_range(0, 6))
            0: line_text.push_back(CH_SPACE);
            1: line_text.push_back(CH_COMMA);
            2: line_text.push_back(CH_TAB);
            3: line_text.push_back(CH_PLUS);
            4: line_text.push_back(CH_NEWLINE);
            5: line_text.push_back(CHAR_W'($urandom_range(128, 255)));
            default: line_text.push_back(CHAR_W'($urandom_range(1, 47)));
        endcase
    endtask

    // optional sign, integer digits, optional point and fraction digits
    task automatic push_number();
        bit neg_sign;
        bit all_nines;
        int n_int;
        int n_frac;
        neg_sign  = ($urandom_range(0, 2) == 0);
        all_nines = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            n_int     = $urandom_range(5, 7);
            all_nines = $urandom_range(0, 1);
        end else begin
            n_int = neg_sign ? $urandom_range(0, 3) : $urandom_range(1, 4);
        end
        if (neg_sign) line_text.push_back(CH_MINUS);
        for (int i = 0; i < n_int; i++)
            line_text.push_back(all_nines ? CH_NINE : CH_ZERO + CHAR_W'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) != 0) begin
            line_text.push_back(CH_POINT);
            n_frac = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
            for (int i = 0; i < n_frac; i++)
                line_text.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
        end
    endtask

    // a vertex line: mostly well formed, some cut short, some plain noise
    task automatic send_random_line();
        int pick;
        int cut;
        int n_noise;
        pick = $urandom_range(0, 99);
        line_text.delete();
        if (pick < 12) begin
            n_noise = $urandom_range(1, 8);
            for (int i = 0; i < n_noise; i++)
                send_byte(CHAR_W'($urandom_range(0, 255)), i == 0 && $urandom_range(0, 3) == 0);
        end else begin
            if ($urandom_range(0, 3) == 0) line_text.push_back(CH_SPACE);
            for (int k = 0; k < 3; k++) begin
                push_number();
                if (k < 2 || $urandom_range(0, 1) == 0) begin
                    push_separator();
                    if ($urandom_range(0, 3) == 0) push_separator();
                end
            end
            // trailing text after the third number is skipped
            if ($urandom_range(0, 3) == 0) push_number();
            line_text.push_back(($urandom_range(0, 4) == 0) ? CH_NUL : CH_NEWLINE);
            if (pick < 24) begin
                cut = $urandom_range(1, line_text.size() - 1);
                line_text = line_text[0:cut-1];
                if ($urandom_range(0, 1) == 0) line_text.push_back(CH_NUL);
            end
            foreach (line_text[i]) send_byte(line_text[i], i == 0);
            items_sent += line_text.size();
        end
    endtask

    // stimulus and verdict
    initial begin
        int target;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // text outside a vertex is ignored
        send_text("x7\n", 1'b0);
        // minus with fraction only, plus skipped, clamped integer, empty fraction
        send_text("-.5+99999 7.\n", 1'b1);
        // newline while searching, lone minus, then nul abandons the vertex
        send_text("\n-", 1'b1);
        send_byte(CH_NUL, 1'b0);
        // tenth fraction digit dropped, negative zero, nul ends the line
        send_text("9.1234567890-.-", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NUL, 1'b0);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  hold_left = HOLD_CYCLES; end
                1: begin send_idle_pct = 56; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 56; end
                3: begin send_idle_pct = 30; stall_pct = 30; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) send_random_line();
        end

        s_tvalid  <= 1'b0;
        stall_pct = 0;
        while (vertices_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
